// File: rtl/ple_pkg.sv
// Package for the positional list engine: sizes, operation codes, sequencer
// states and the structs passed between the control and storage modules.
// No dependencies.
`default_nettype none

package ple_pkg;

   localparam int CAPACITY  = 32;
   localparam int DATA_W    = 32;
   localparam int FUNC_W    = 3;
   localparam int POS_W     = 8;
   localparam int RSP_CNT_W = 6;
   localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INS_FIRST = 3'd0,
      FUNC_INS_LAST  = 3'd1,
      FUNC_INS_POS   = 3'd2,
      FUNC_DEL_FIRST = 3'd3,
      FUNC_DEL_LAST  = 3'd4,
      FUNC_DEL_POS   = 3'd5
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_PUT,
      ST_DEL_GET,
      ST_DEL_TAKE,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_DEL_FIN
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [IDX_W-1:0]  rd_addr;
   } mem_cmd_type;

   typedef struct packed {
      logic                     valid;
      logic                     ok;
      logic signed [DATA_W-1:0] removed_value;
      logic [CNT_W-1:0]         count;
   } done_type;

   // Reports the element count in the fixed width of the result word.
   function automatic logic [RSP_CNT_W-1:0] to_rsp_count(input logic [CNT_W-1:0] c);
      logic [CNT_W+RSP_CNT_W-1:0] wide;
      wide = {{RSP_CNT_W{1'b0}}, c};
      return wide[RSP_CNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/ple_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on ple_pkg.
`default_nettype none

interface ple_req_if;
   logic                              valid;
   logic                              ready;
   logic [ple_pkg::FUNC_W-1:0]        func;
   logic signed [ple_pkg::DATA_W-1:0] new_value;
   logic [ple_pkg::POS_W-1:0]         position;

   modport source (output valid, func, new_value, position, input ready);
   modport sink (input valid, func, new_value, position, output ready);
   modport monitor (input valid, ready, func, new_value, position);
endinterface

interface ple_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              ok;
   logic signed [ple_pkg::DATA_W-1:0] removed_value;
   logic [ple_pkg::RSP_CNT_W-1:0]     count;

   modport source (output valid, ok, removed_value, count, input ready);
   modport sink (input valid, ok, removed_value, count, output ready);
   modport monitor (input valid, ready, ok, removed_value, count);
endinterface

`default_nettype wire

// File: rtl/ple_store.sv
// Element storage: one write port and one registered read port.
// Depends on ple_pkg.
`default_nettype none

module ple_store (
   input  wire                               clock,
   input  ple_pkg::mem_cmd_type              mem_cmd,
   output logic [ple_pkg::DATA_W-1:0]        rd_data
);
   import ple_pkg::*;

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem[mem_cmd.wr_addr] <= mem_cmd.wr_data;
      end
      rd_data_ff <= mem[mem_cmd.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/ple_ctrl.sv
// Sequencer for the positional list engine: decodes an operation, checks it
// against the count, then shifts elements one per read/write pair.
// Depends on ple_pkg.
`default_nettype none

module ple_ctrl (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire [ple_pkg::FUNC_W-1:0]          func,
   input  wire [ple_pkg::DATA_W-1:0]          new_value,
   input  wire [ple_pkg::POS_W-1:0]           position,
   input  wire                                rsp_busy,
   output logic                               req_ready,
   output ple_pkg::mem_cmd_type               mem_cmd,
   input  wire [ple_pkg::DATA_W-1:0]          rd_data,
   output ple_pkg::done_type                  done
);
   import ple_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [DATA_W-1:0] removed_ff, removed_in;

   logic              accept;
   logic              is_insert, is_delete, pos_ok, op_ok;
   logic [CMP_W-1:0]  count_ext, pos_ext, slot_cmp;
   logic [CNT_W-1:0]  ptr_dec;
   logic [CNT_W:0]    ptr_inc1, ptr_inc2, count_w;

   assign accept    = req_valid && req_ready;
   assign ptr_dec   = ptr_ff - 1'b1;
   assign ptr_inc1  = {1'b0, ptr_ff} + 1'b1;
   assign ptr_inc2  = {1'b0, ptr_ff} + 2'd2;
   assign count_w   = {1'b0, count_ff};

   // Operation decode and range check against the current count.
   always_comb begin
      count_ext = CMP_W'(count_ff);
      pos_ext   = CMP_W'(position);
      is_insert = 1'b0;
      is_delete = 1'b0;
      pos_ok    = 1'b1;
      slot_cmp  = '0;
      case (func_type'(func))
         FUNC_INS_FIRST: begin
            is_insert = 1'b1;
         end
         FUNC_INS_LAST: begin
            is_insert = 1'b1;
            slot_cmp  = count_ext;
         end
         FUNC_INS_POS: begin
            is_insert = 1'b1;
            slot_cmp  = pos_ext - 1'b1;
            pos_ok    = (position != '0);
         end
         FUNC_DEL_FIRST: begin
            is_delete = 1'b1;
         end
         FUNC_DEL_LAST: begin
            is_delete = 1'b1;
            slot_cmp  = count_ext - 1'b1;
         end
         FUNC_DEL_POS: begin
            is_delete = 1'b1;
            slot_cmp  = pos_ext - 1'b1;
            pos_ok    = (position != '0);
         end
         default: begin
            is_insert = 1'b0;
         end
      endcase
      op_ok = pos_ok &&
              ((is_insert && (count_ff < CAP_COUNT) && (slot_cmp <= count_ext)) ||
               (is_delete && (count_ff != '0) && (slot_cmp < count_ext)));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && op_ok) begin
               if (is_delete) begin
                  state_in = ST_DEL_GET;
               end else if (slot_cmp < count_ext) begin
                  state_in = ST_INS_RD;
               end else begin
                  state_in = ST_INS_PUT;
               end
            end
         end
         ST_INS_RD: state_in = ST_INS_WR;
         ST_INS_WR: begin
            if (ptr_dec > CNT_W'(slot_ff)) begin
               state_in = ST_INS_RD;
            end else begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: state_in = ST_IDLE;
         ST_DEL_GET: state_in = ST_DEL_TAKE;
         ST_DEL_TAKE: begin
            if (ptr_inc1 < count_w) begin
               state_in = ST_DEL_RD;
            end else begin
               state_in = ST_DEL_FIN;
            end
         end
         ST_DEL_RD: state_in = ST_DEL_WR;
         ST_DEL_WR: begin
            if (ptr_inc2 < count_w) begin
               state_in = ST_DEL_RD;
            end else begin
               state_in = ST_DEL_FIN;
            end
         end
         ST_DEL_FIN: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      req_ready          = (state_ff == ST_IDLE) && !rsp_busy;
      count_in           = count_ff;
      ptr_in             = ptr_ff;
      slot_in            = slot_ff;
      value_in           = value_ff;
      removed_in         = removed_ff;
      mem_cmd.wr_en      = 1'b0;
      mem_cmd.wr_addr    = ptr_ff[IDX_W-1:0];
      mem_cmd.wr_data    = rd_data;
      mem_cmd.rd_addr    = slot_ff;
      done.valid         = 1'b0;
      done.ok            = 1'b0;
      done.removed_value = '0;
      done.count         = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               slot_in  = slot_cmp[IDX_W-1:0];
               value_in = new_value;
               ptr_in   = is_insert ? count_ff : CNT_W'(slot_cmp);
               // A rejected word is answered at once with the list untouched.
               done.valid = !op_ok;
            end
         end
         ST_INS_RD: begin
            mem_cmd.rd_addr = ptr_dec[IDX_W-1:0];
         end
         ST_INS_WR: begin
            mem_cmd.wr_en = 1'b1;
            ptr_in        = ptr_dec;
         end
         ST_INS_PUT: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = slot_ff;
            mem_cmd.wr_data = value_ff;
            count_in        = count_ff + 1'b1;
            done.valid      = 1'b1;
            done.ok         = 1'b1;
            done.count      = count_in;
         end
         ST_DEL_GET: begin
            mem_cmd.rd_addr = slot_ff;
         end
         ST_DEL_TAKE: begin
            removed_in = rd_data;
         end
         ST_DEL_RD: begin
            mem_cmd.rd_addr = ptr_inc1[IDX_W-1:0];
         end
         ST_DEL_WR: begin
            mem_cmd.wr_en = 1'b1;
            ptr_in        = ptr_inc1[CNT_W-1:0];
         end
         ST_DEL_FIN: begin
            count_in           = count_ff - 1'b1;
            done.valid         = 1'b1;
            done.ok            = 1'b1;
            done.removed_value = removed_ff;
            done.count         = count_in;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      ptr_ff     <= ptr_in;
      slot_ff    <= slot_in;
      value_ff   <= value_in;
      removed_ff <= removed_in;
   end

endmodule

`default_nettype wire

// File: rtl/positional_list_engine_top.sv
// Positional list engine: ordered list of signed words with insert/delete
// at front, back or a 1-based position. Insert and delete move one element
// per read/write pair through the storage's read and write ports; a rejected
// word leaves the list untouched. One word is in flight; the next is taken
// after the response leaves. Synchronous reset empties the list.
`default_nettype none

module positional_list_engine_top (
   input  wire         clock,
   input  wire         reset,
   ple_req_if.sink     req_if,
   ple_rsp_if.source   rsp_if
);
   import ple_pkg::*;

   mem_cmd_type              mem_cmd;
   done_type                 done;
   logic [DATA_W-1:0]        rd_data;
   logic                     req_ready;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff;
   logic signed [DATA_W-1:0] rsp_removed_ff;
   logic [RSP_CNT_W-1:0]     rsp_count_ff;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .func      (req_if.func),
      .new_value (req_if.new_value),
      .position  (req_if.position),
      .rsp_busy  (rsp_valid_ff),
      .req_ready (req_ready),
      .mem_cmd   (mem_cmd),
      .rd_data   (rd_data),
      .done      (done)
   );

   ple_store u_store (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data)
   );

   assign req_if.ready = req_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (done.valid) begin
         rsp_ok_ff      <= done.ok;
         rsp_removed_ff <= done.removed_value;
         rsp_count_ff   <= to_rsp_count(done.count);
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.ok            = rsp_ok_ff;
   assign rsp_if.removed_value = rsp_removed_ff;
   assign rsp_if.count         = rsp_count_ff;

endmodule

`default_nettype wire

// File: rtl/ple_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg and the channel interfaces.
`default_nettype none

module ple_checker (
   input  wire          clock,
   input  wire          reset,
   ple_req_if.sink      req_if,
   ple_rsp_if.source    rsp_if
);
   import ple_pkg::*;

   // No response word may come out of reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("response valid right after reset");

   // A held response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=>
         rsp_if.valid && $stable(rsp_if.ok) && $stable(rsp_if.removed_value) &&
         $stable(rsp_if.count))
      else $error("response changed while stalled");

   // Only one word is in flight: the block is busy right after an accept.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request taken while another is in flight");

   // A rejected operation removes nothing.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ok |-> rsp_if.removed_value == '0)
      else $error("rejected operation reports a removed word");

   // The reported count never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (CAPACITY > 63) || (int'(rsp_if.count) <= CAPACITY))
      else $error("count beyond capacity");

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);

`default_nettype wire
